### hw/rtl/ebcalu_pkg.sv
// ----------------------------------------------------------------------------
// ebcalu_pkg
// Shared types, command codes and flag positions of the 8-bit CPU ALU.
// ----------------------------------------------------------------------------
package ebcalu_pkg;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_ADC    = 5'd1,
        CMD_SUB    = 5'd2,
        CMD_SBC    = 5'd3,
        CMD_AND    = 5'd4,
        CMD_XOR    = 5'd5,
        CMD_OR     = 5'd6,
        CMD_CP     = 5'd7,
        CMD_INC    = 5'd8,
        CMD_DEC    = 5'd9,
        CMD_ADD16  = 5'd10,
        CMD_ADD_SP = 5'd11,
        CMD_RLCA   = 5'd12,
        CMD_RRCA   = 5'd13,
        CMD_RLA    = 5'd14,
        CMD_RRA    = 5'd15,
        CMD_RLC    = 5'd16,
        CMD_RRC    = 5'd17,
        CMD_RL     = 5'd18,
        CMD_RR     = 5'd19,
        CMD_SLA    = 5'd20,
        CMD_SRA    = 5'd21,
        CMD_SWAP   = 5'd22,
        CMD_SRL    = 5'd23,
        CMD_BIT    = 5'd24,
        CMD_RES    = 5'd25,
        CMD_SET    = 5'd26,
        CMD_DAA    = 5'd27,
        CMD_CPL    = 5'd28,
        CMD_SCF    = 5'd29,
        CMD_CCF    = 5'd30
    } command_t;

    typedef struct packed {
        logic [4:0]  command;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
        logic        write_back;
    } alu_rsp_t;

endpackage

### hw/rtl/ebcalu_core.sv
// ----------------------------------------------------------------------------
// ebcalu_core
// Single-pass combinational datapath that computes result, flags and
// write-back for one ALU item.
// ----------------------------------------------------------------------------
module ebcalu_core
    import ebcalu_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic        nin;
    logic        hin;
    logic        zin;
    logic        use_carry;
    logic [8:0]  add9;
    logic [4:0]  addh;
    logic [8:0]  sub9;
    logic [4:0]  subh;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] add17;
    logic [12:0] add13;
    logic [15:0] sp16;
    logic [8:0]  spc9;
    logic [4:0]  sph5;
    logic [7:0]  bit_mask;
    logic [7:0]  daa_corr;
    logic        daa_cout;
    logic [7:0]  daa8;

    assign a   = req.operand_a[7:0];
    assign b   = req.operand_b[7:0];
    assign cin = req.flags_in[FLAG_C];
    assign nin = req.flags_in[FLAG_N];
    assign hin = req.flags_in[FLAG_H];
    assign zin = req.flags_in[FLAG_Z];

    assign use_carry = ((req.command == CMD_ADC) || (req.command == CMD_SBC)) && cin;

    assign add9  = {1'b0, a} + {1'b0, b} + {8'd0, use_carry};
    assign addh  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_carry};
    assign sub9  = {1'b0, a} - {1'b0, b} - {8'd0, use_carry};
    assign subh  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_carry};
    assign inc8  = a + 8'd1;
    assign dec8  = a - 8'd1;
    assign add17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
    assign add13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
    assign sp16  = req.operand_a + {{8{b[7]}}, b};
    assign spc9  = {1'b0, a} + {1'b0, b};
    assign sph5  = {1'b0, a[3:0]} + {1'b0, b[3:0]};

    assign bit_mask = 8'(8'h01 << req.bit_index);

    always_comb
    begin
        daa_corr = 8'h00;
        daa_cout = 1'b0;
        if (hin || (!nin && (a[3:0] > 4'd9)))
        begin
            daa_corr = 8'h06;
        end
        if (cin || (!nin && (a > 8'h99)))
        begin
            daa_corr = daa_corr | 8'h60;
            daa_cout = 1'b1;
        end
    end

    assign daa8 = nin ? (a - daa_corr) : (a + daa_corr);

    always_comb
    begin
        logic [7:0] r8;
        logic [15:0] r16;
        logic [3:0] f;
        logic wb;
        logic wide;

        r8   = a;
        r16  = 16'd0;
        f    = req.flags_in;
        wb   = 1'b1;
        wide = 1'b0;

        unique case (req.command)
            CMD_ADD, CMD_ADC:
            begin
                r8 = add9[7:0];
                f  = {add9[7:0] == 8'd0, 1'b0, addh[4], add9[8]};
            end
            CMD_SUB, CMD_SBC:
            begin
                r8 = sub9[7:0];
                f  = {sub9[7:0] == 8'd0, 1'b1, subh[4], sub9[8]};
            end
            CMD_CP:
            begin
                f  = {sub9[7:0] == 8'd0, 1'b1, subh[4], sub9[8]};
                wb = 1'b0;
            end
            CMD_AND:
            begin
                r8 = a & b;
                f  = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            CMD_XOR:
            begin
                r8 = a ^ b;
                f  = {(a ^ b) == 8'd0, 3'b000};
            end
            CMD_OR:
            begin
                r8 = a | b;
                f  = {(a | b) == 8'd0, 3'b000};
            end
            CMD_INC:
            begin
                r8 = inc8;
                f  = {inc8 == 8'd0, 1'b0, inc8[3:0] == 4'h0, cin};
            end
            CMD_DEC:
            begin
                r8 = dec8;
                f  = {dec8 == 8'd0, 1'b1, dec8[3:0] == 4'hF, cin};
            end
            CMD_ADD16:
            begin
                wide = 1'b1;
                r16  = add17[15:0];
                f    = {zin, 1'b0, add13[12], add17[16]};
            end
            CMD_ADD_SP:
            begin
                wide = 1'b1;
                r16  = sp16;
                f    = {1'b0, 1'b0, sph5[4], spc9[8]};
            end
            CMD_RLCA, CMD_RLC:
            begin
                r8 = {a[6:0], a[7]};
                f  = {(req.command == CMD_RLC) && (a == 8'd0), 2'b00, a[7]};
            end
            CMD_RRCA, CMD_RRC:
            begin
                r8 = {a[0], a[7:1]};
                f  = {(req.command == CMD_RRC) && (a == 8'd0), 2'b00, a[0]};
            end
            CMD_RLA, CMD_RL:
            begin
                r8 = {a[6:0], cin};
                f  = {(req.command == CMD_RL) && ({a[6:0], cin} == 8'd0), 2'b00, a[7]};
            end
            CMD_RRA, CMD_RR:
            begin
                r8 = {cin, a[7:1]};
                f  = {(req.command == CMD_RR) && ({cin, a[7:1]} == 8'd0), 2'b00, a[0]};
            end
            CMD_SLA:
            begin
                r8 = {a[6:0], 1'b0};
                f  = {a[6:0] == 7'd0, 2'b00, a[7]};
            end
            CMD_SRA:
            begin
                r8 = {a[7], a[7:1]};
                f  = {{a[7], a[7:1]} == 8'd0, 2'b00, a[0]};
            end
            CMD_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                f  = {a == 8'd0, 3'b000};
            end
            CMD_SRL:
            begin
                r8 = {1'b0, a[7:1]};
                f  = {a[7:1] == 7'd0, 2'b00, a[0]};
            end
            CMD_BIT:
            begin
                f  = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
                wb = 1'b0;
            end
            CMD_RES:
            begin
                r8 = a & ~bit_mask;
            end
            CMD_SET:
            begin
                r8 = a | bit_mask;
            end
            CMD_DAA:
            begin
                r8 = daa8;
                f  = {daa8 == 8'd0, nin, 1'b0, daa_cout};
            end
            CMD_CPL:
            begin
                r8 = ~a;
                f  = {zin, 1'b1, 1'b1, cin};
            end
            CMD_SCF:
            begin
                f  = {zin, 2'b00, 1'b1};
                wb = 1'b0;
            end
            CMD_CCF:
            begin
                f  = {zin, 2'b00, ~cin};
                wb = 1'b0;
            end
            default:
            begin
                r8 = 8'd0;
                wb = 1'b0;
            end
        endcase

        rsp.result     = wide ? r16 : {8'd0, r8};
        rsp.flags_out  = f;
        rsp.write_back = wb;
    end

endmodule

### hw/rtl/eight_bit_cpu_alu_with_flags_top.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags_top: execute ALU of an 8-bit CPU with flags.
// Pipeline: input register, one ALU pass, result register.
// Throughput is one item per cycle unless rsp_ready is low while the result register is full.
// Reset clears both valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_with_flags_top
    import ebcalu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  alu_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output alu_rsp_t rsp
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    alu_req_t s1_data_reg;
    logic     s2_valid_reg;
    logic     s2_valid_next;
    alu_rsp_t s2_data_reg;
    alu_rsp_t alu_rsp;
    logic     s2_load;
    logic     s1_load;

    ebcalu_core u_core (
        .req (s1_data_reg),
        .rsp (alu_rsp)
    );

    assign s2_load   = s1_valid_reg && (!s2_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s2_load;
    assign s1_load   = req_valid && req_ready;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s2_load);
    assign s2_valid_next = s2_load || (s2_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= req;
        end
        if (s2_load)
        begin
            s2_data_reg <= alu_rsp;
        end
    end

    assign rsp_valid = s2_valid_reg;
    assign rsp       = s2_data_reg;

`ifndef NO_ASSERTIONS
    a_rsp_from_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s2_valid_reg) |-> $past(s1_valid_reg))
        else $error("Result appeared without an item in the input register.");

    a_stage1_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("Stalled item in the input register was lost or changed.");

    a_no_write_back : assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && ((s1_data_reg.command == CMD_CP) || (s1_data_reg.command == CMD_BIT) ||
                     (s1_data_reg.command == CMD_SCF) || (s1_data_reg.command == CMD_CCF)))
        |=> !s2_data_reg.write_back)
        else $error("Compare, bit test or carry operation requested a write-back.");

    a_byte_result : assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && (s1_data_reg.command != CMD_ADD16) &&
         (s1_data_reg.command != CMD_ADD_SP))
        |=> (s2_data_reg.result[15:8] == 8'd0))
        else $error("Byte operation produced a nonzero high byte.");
`endif

endmodule
